/* rtl/temporal_median_background_top_defines.svh */
// Assertion macros shared by the temporal median background RTL.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef TEMPORAL_MEDIAN_BACKGROUND_TOP_DEFINES_SVH
`define TEMPORAL_MEDIAN_BACKGROUND_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define TMB_AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tmb assertion failed");

// Next-cycle implication, off while reset is low.
`define TMB_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tmb assertion failed");

`endif

/* rtl/tmb_pkg.sv */
// Package for the temporal median background block: widths, types and the
// sorting network layers. No dependencies.
package tmb_pkg;

    localparam int NUM_SAMPLES    = 8;
    localparam int SAMPLE_W       = 8;
    localparam int CNT_W          = 4;
    localparam int IDX_W          = $clog2(NUM_SAMPLES);
    localparam int DEF_MAX_FRAMES = 8;
    localparam int NET_LAYERS     = 6;
    localparam int LAYERS_PER_STG = 2;
    localparam int SORT_STAGES    = NET_LAYERS / LAYERS_PER_STG;

    localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(8);
    localparam logic [SAMPLE_W-1:0] PAD_SAMPLE = '1;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef t_sample t_vec [NUM_SAMPLES];
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_count;

    typedef struct packed {
        logic valid;
        t_idx sel;
    } t_stage_ctl;

    typedef struct packed {
        logic    valid;
        t_sample median;
    } t_stage_out;

    function automatic t_vec compare_swap(t_vec v, int lo, int hi);
        t_vec r;
        r = v;
        if (v[lo] > v[hi]) begin
            r[lo] = v[hi];
            r[hi] = v[lo];
        end
        return r;
    endfunction

    // Batcher odd-even merge network for eight keys, one layer per call.
    function automatic t_vec net_layer(t_vec v, int layer);
        t_vec r;
        r = v;
        case (layer)
            0: begin
                r = compare_swap(r, 0, 1);
                r = compare_swap(r, 2, 3);
                r = compare_swap(r, 4, 5);
                r = compare_swap(r, 6, 7);
            end
            1: begin
                r = compare_swap(r, 0, 2);
                r = compare_swap(r, 1, 3);
                r = compare_swap(r, 4, 6);
                r = compare_swap(r, 5, 7);
            end
            2: begin
                r = compare_swap(r, 1, 2);
                r = compare_swap(r, 5, 6);
            end
            3: begin
                r = compare_swap(r, 0, 4);
                r = compare_swap(r, 1, 5);
                r = compare_swap(r, 2, 6);
                r = compare_swap(r, 3, 7);
            end
            4: begin
                r = compare_swap(r, 2, 4);
                r = compare_swap(r, 3, 5);
            end
            5: begin
                r = compare_swap(r, 1, 2);
                r = compare_swap(r, 3, 4);
                r = compare_swap(r, 5, 6);
            end
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

/* rtl/tmb_if.sv */
// Valid/ready channel interfaces for the temporal median background block.
// Depends on tmb_pkg.
interface tmb_in_if;
    import tmb_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_0;
    t_sample sample_1;
    t_sample sample_2;
    t_sample sample_3;
    t_sample sample_4;
    t_sample sample_5;
    t_sample sample_6;
    t_sample sample_7;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7,
        output ready
    );
endinterface

interface tmb_out_if;
    import tmb_pkg::*;

    logic    valid;
    logic    ready;
    t_sample median_value;

    modport source (output valid, median_value, input ready);
    modport sink (input valid, median_value, output ready);
endinterface

/* rtl/temporal_median_background_top.sv */
// Temporal median background estimator, top level.
// Depends on tmb_pkg, tmb_if.sv, tmb_sort_pipe and the assertion macro header.
//
// Each item on i_pix carries one pixel component byte from each of eight
// frames; o_bg returns one item per input item, the median of the first
// images_in_use samples (sorted ascending, element at index count/2, so the
// upper median for even counts). The count is clamped to 1..MAX_FRAMES.
// Throughput is one item per clock while o_bg takes results; from acceptance
// to o_bg.valid an item passes three register stages of the sorting
// network (two comparator layers each) plus the output register that holds
// the selected median. Back-pressure on o_bg reaches the input in the same
// cycle through the stage ready chain, but an empty stage still loads, so
// the pipeline keeps accepting until all four registers hold items. Write
// images_in_use only while the block is idle; it takes effect for the next
// accepted item.
`include "temporal_median_background_top_defines.svh"

module temporal_median_background_top #(
    parameter int MAX_FRAMES = tmb_pkg::DEF_MAX_FRAMES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [tmb_pkg::CNT_W-1:0] i_cfg_wdata,
    tmb_in_if.sink                i_pix,
    tmb_out_if.source             o_bg
);
    import tmb_pkg::*;

    // images_in_use, stored raw; clamping happens on the read side
    t_count     r_images_in_use;
    t_count     eff_count;
    t_stage_ctl pipe_ctl;
    t_vec       raw_vec;
    t_vec       pipe_vec;
    t_stage_out pipe_out;
    logic       pipe_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_images_in_use <= RESET_COUNT;
        end else if (i_cfg_we) begin
            r_images_in_use <= i_cfg_wdata;
        end
    end

    // effective count: zero reads as one, anything past MAX_FRAMES saturates
    always_comb begin
        if (r_images_in_use == '0) begin
            eff_count = CNT_W'(1);
        end else if (r_images_in_use > CNT_W'(MAX_FRAMES)) begin
            eff_count = CNT_W'(MAX_FRAMES);
        end else begin
            eff_count = r_images_in_use;
        end
    end

    assign raw_vec[0] = i_pix.sample_0;
    assign raw_vec[1] = i_pix.sample_1;
    assign raw_vec[2] = i_pix.sample_2;
    assign raw_vec[3] = i_pix.sample_3;
    assign raw_vec[4] = i_pix.sample_4;
    assign raw_vec[5] = i_pix.sample_5;
    assign raw_vec[6] = i_pix.sample_6;
    assign raw_vec[7] = i_pix.sample_7;

    // Unused samples are forced to the top code. They then sort to the end
    // and the first eff_count sorted keys are exactly the live samples, so
    // index count/2 picks the right one.
    always_comb begin
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            pipe_vec[i] = (i < int'(eff_count)) ? raw_vec[i] : PAD_SAMPLE;
        end
    end

    assign pipe_ctl.valid = i_pix.valid;
    assign pipe_ctl.sel   = IDX_W'(eff_count >> 1);

    tmb_sort_pipe u_sort (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (pipe_ctl),
        .i_vec       (pipe_vec),
        .o_in_ready  (pipe_in_ready),
        .o_out       (pipe_out),
        .i_out_ready (o_bg.ready)
    );

    assign i_pix.ready       = pipe_in_ready;
    assign o_bg.valid        = pipe_out.valid;
    assign o_bg.median_value = pipe_out.median;

    // input only stalls when a result is sitting unclaimed at the output
    `TMB_AST_SAME(a_stall_cause, !i_pix.ready, o_bg.valid && !o_bg.ready)
    // a zero count is floored to one on the very next cycle
    `TMB_AST_NEXT(a_cfg_floor, i_cfg_we && (i_cfg_wdata == '0), eff_count == CNT_W'(1))
    // with the output drained, an accepted item reaches o_bg.valid through all four registers
    `TMB_AST_SAME(a_latency,
        $past(i_pix.valid && i_pix.ready, 4) && $past(i_rst_n, 4) && $past(i_rst_n, 3)
            && $past(i_rst_n, 2) && $past(i_rst_n, 1) && $past(o_bg.ready, 3)
            && $past(o_bg.ready, 2) && $past(o_bg.ready, 1),
        o_bg.valid)

endmodule

/* rtl/tmb_sort_pipe.sv */
// Pipelined eight-key sorting network with median select and output register.
// Depends on tmb_pkg.
module tmb_sort_pipe (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tmb_pkg::t_stage_ctl    i_ctl,
    input  tmb_pkg::t_vec          i_vec,
    output logic                   o_in_ready,
    output tmb_pkg::t_stage_out    o_out,
    input  logic                   i_out_ready
);
    import tmb_pkg::*;

    logic       r_valid [SORT_STAGES];
    t_idx       r_sel   [SORT_STAGES];
    t_vec       r_vec   [SORT_STAGES];
    t_vec       n_vec   [SORT_STAGES];
    logic       st_rdy  [SORT_STAGES+1];
    logic       r_out_valid;
    t_sample    r_median;

    // a stage may load when it is empty or its successor loads too
    always_comb begin
        st_rdy[SORT_STAGES] = !r_out_valid || i_out_ready;
        for (int k = SORT_STAGES - 1; k >= 0; k--) begin
            st_rdy[k] = !r_valid[k] || st_rdy[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < SORT_STAGES; k++) begin
            t_vec src;
            src = (k == 0) ? i_vec : r_vec[(k == 0) ? 0 : k - 1];
            for (int l = 0; l < LAYERS_PER_STG; l++) begin
                src = net_layer(src, k * LAYERS_PER_STG + l);
            end
            n_vec[k] = src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SORT_STAGES; k++) r_valid[k] <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (st_rdy[0]) r_valid[0] <= i_ctl.valid;
            for (int k = 1; k < SORT_STAGES; k++) begin
                if (st_rdy[k]) r_valid[k] <= r_valid[k-1];
            end
            if (st_rdy[SORT_STAGES]) r_out_valid <= r_valid[SORT_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_rdy[0]) begin
            r_vec[0] <= n_vec[0];
            r_sel[0] <= i_ctl.sel;
        end
        for (int k = 1; k < SORT_STAGES; k++) begin
            if (st_rdy[k]) begin
                r_vec[k] <= n_vec[k];
                r_sel[k] <= r_sel[k-1];
            end
        end
        if (st_rdy[SORT_STAGES]) begin
            r_median <= r_vec[SORT_STAGES-1][r_sel[SORT_STAGES-1]];
        end
    end

    assign o_in_ready   = st_rdy[0];
    assign o_out.valid  = r_out_valid;
    assign o_out.median = r_median;

endmodule
